FILE: src/smu_pkg.sv
package smu_pkg;

  // instruction codes as carried on the input channel
  typedef enum logic [3:0] {
    OP_NOP  = 4'd0,
    OP_PUSH = 4'd1,
    OP_POP  = 4'd2,
    OP_ADD  = 4'd3,
    OP_SUB  = 4'd4,
    OP_MUL  = 4'd5,
    OP_DIV  = 4'd6,
    OP_SWAP = 4'd7,
    OP_INC  = 4'd8,
    OP_DEC  = 4'd9,
    OP_QUIT = 4'd10
  } op_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_QUIT      = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_DIVZERO   = 3'd4,
    ST_UNKNOWN   = 3'd5,
    ST_HALTED    = 3'd6
  } status_t;

  // instruction class as sorted by the front end
  typedef enum logic [3:0] {
    K_NOP,
    K_PUSH,
    K_POP,
    K_ARITH,
    K_DIV,
    K_SWAP,
    K_STEP,
    K_QUIT,
    K_BAD
  } kind_t;

  // arithmetic selector for the add, sub and mul binary ops
  typedef enum logic [1:0] {
    A_ADD,
    A_SUB,
    A_MUL
  } arith_t;

  // one decoded word waiting in the queue
  typedef struct packed {
    kind_t       kind;
    arith_t      arith;
    logic        dec;
    logic [31:0] imm;
  } entry_t;

  // back-end state seen by the top-level checks
  typedef struct packed {
    logic halted;
    logic busy;
  } bk_mon_t;

  // back-end states
  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FILL
  } bk_state_t;

endpackage

FILE: src/smu_if.sv
interface smu_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         op;
  logic signed [31:0] immediate;

  modport source (output valid, output op, output immediate, input ready);
  modport sink (input valid, input op, input immediate, output ready);
endinterface

interface smu_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [31:0] top_value;
  logic               stack_empty;
  logic [31:0]        executed_count;

  modport source (output valid, output status, output top_value, output stack_empty,
                  output executed_count, input ready);
  modport sink (input valid, input status, input top_value, input stack_empty,
                input executed_count, output ready);
endinterface

FILE: src/smu_ram.sv
module smu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/smu_div.sv
module smu_div
  import smu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy;
  logic [5:0]  cnt;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dsr;
  logic        neg;
  logic [32:0] trial;
  logic [31:0] rem_shift;

  // one restoring step per cycle on magnitudes
  always_comb begin
    rem_shift = {rem[30:0], quo[31]};
    trial     = {1'b0, rem_shift} - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: load magnitudes, shift and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend[31] ? (32'd0 - dividend) : dividend;
      dsr <= divisor[31] ? (32'd0 - divisor) : divisor;
      neg <= dividend[31] ^ divisor[31];
    end else if (busy) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= rem_shift;
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  assign quotient = neg ? (32'd0 - quo) : quo;

endmodule

FILE: src/smu_front.sv
module smu_front
  import smu_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  smu_in_if.sink    in_ch,
  output logic      q_valid,
  output entry_t    q_entry,
  input  logic      q_pop
);

  entry_t    slots [2];
  logic      wr_ptr;
  logic      rd_ptr;
  logic [1:0] fill;
  logic      push;
  entry_t    dec_entry;

  // sort the incoming word into an instruction class
  always_comb begin
    dec_entry.imm   = in_ch.immediate;
    dec_entry.arith = A_ADD;
    dec_entry.dec   = 1'b0;
    dec_entry.kind  = K_BAD;
    unique case (in_ch.op)
      OP_NOP:  dec_entry.kind = K_NOP;
      OP_PUSH: dec_entry.kind = K_PUSH;
      OP_POP:  dec_entry.kind = K_POP;
      OP_ADD:  dec_entry.kind = K_ARITH;
      OP_SUB: begin
        dec_entry.kind  = K_ARITH;
        dec_entry.arith = A_SUB;
      end
      OP_MUL: begin
        dec_entry.kind  = K_ARITH;
        dec_entry.arith = A_MUL;
      end
      OP_DIV:  dec_entry.kind = K_DIV;
      OP_SWAP: dec_entry.kind = K_SWAP;
      OP_INC:  dec_entry.kind = K_STEP;
      OP_DEC: begin
        dec_entry.kind = K_STEP;
        dec_entry.dec  = 1'b1;
      end
      OP_QUIT: dec_entry.kind = K_QUIT;
      default: dec_entry.kind = K_BAD;
    endcase
  end

  assign in_ch.ready = (fill != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (fill != 2'd0);
  assign q_entry     = slots[rd_ptr];

  // hold decoded words in a two-entry queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= dec_entry;
    end
  end

endmodule

FILE: src/smu_back.sv
module smu_back
  import smu_pkg::*;
#(
  parameter int STACK_DEPTH = 2048
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  entry_t    q_entry,
  output logic      q_pop,
  smu_out_if.source out_ch,
  output bk_mon_t   mon
);

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  bk_state_t   state, state_next;
  logic [31:0] tos, tos_next;
  logic [31:0] nos, nos_next;
  logic [DW-1:0] depth, depth_next;
  logic [31:0] count, count_next;
  logic        halted, halted_next;
  logic        out_valid;
  logic        finish;
  status_t     st;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [31:0]   rd_data;

  logic          div_start;
  logic          div_done;
  logic [31:0]   div_q;

  logic [31:0] arith_res;
  logic [31:0] prod;
  logic        out_free;

  status_t     o_status;
  logic [31:0] o_top;
  logic        o_empty;
  logic [31:0] o_count;

  smu_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (nos),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  smu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (nos),
    .divisor  (tos),
    .done     (div_done),
    .quotient (div_q)
  );

  // combinational binary ops on the two top entries
  assign prod = nos * tos;
  always_comb begin
    unique case (q_entry.arith)
      A_ADD:   arith_res = nos + tos;
      A_SUB:   arith_res = nos - tos;
      A_MUL:   arith_res = prod;
      default: arith_res = nos + tos;
    endcase
  end

  assign out_free = !out_valid || out_ch.ready;
  assign wr_addr  = AW'(depth - DW'(2));
  assign rd_addr  = AW'(depth - DW'(3));

  // sequence one instruction at a time
  always_comb begin
    state_next  = state;
    tos_next    = tos;
    nos_next    = nos;
    depth_next  = depth;
    count_next  = count;
    halted_next = halted;
    st          = ST_OK;
    finish      = 1'b0;
    q_pop       = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    div_start   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_pop  = 1'b1;
          finish = 1'b1;
          if (halted) begin
            st = ST_HALTED;
          end else begin
            if (count != '1) begin
              count_next = count + 32'd1;
            end
            unique case (q_entry.kind)
              K_NOP: st = ST_OK;
              K_PUSH: begin
                if (depth >= DW'(STACK_DEPTH)) begin
                  st = ST_OVERFLOW;
                end else begin
                  wr_en      = (depth >= DW'(2));
                  nos_next   = tos;
                  tos_next   = q_entry.imm;
                  depth_next = depth + DW'(1);
                end
              end
              K_POP, K_ARITH: begin
                if ((q_entry.kind == K_POP && depth == '0) ||
                    (q_entry.kind == K_ARITH && depth < DW'(2))) begin
                  st = ST_UNDERFLOW;
                end else begin
                  tos_next   = (q_entry.kind == K_POP) ? nos : arith_res;
                  depth_next = depth - DW'(1);
                  if (depth >= DW'(3)) begin
                    rd_en      = 1'b1;
                    finish     = 1'b0;
                    state_next = S_FILL;
                  end
                end
              end
              K_DIV: begin
                if (depth < DW'(2)) begin
                  st = ST_UNDERFLOW;
                end else if (tos == '0) begin
                  st = ST_DIVZERO;
                end else begin
                  div_start  = 1'b1;
                  finish     = 1'b0;
                  state_next = S_DIV;
                end
              end
              K_SWAP: begin
                if (depth < DW'(2)) begin
                  st = ST_UNDERFLOW;
                end else begin
                  tos_next = nos;
                  nos_next = tos;
                end
              end
              K_STEP: begin
                if (depth == '0) begin
                  st = ST_UNDERFLOW;
                end else begin
                  tos_next = q_entry.dec ? (tos - 32'd1) : (tos + 32'd1);
                end
              end
              K_QUIT: st = ST_QUIT;
              default: st = ST_UNKNOWN;
            endcase
            if (st != ST_OK) begin
              halted_next = 1'b1;
            end
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          tos_next   = div_q;
          depth_next = depth - DW'(1);
          if (depth >= DW'(3)) begin
            rd_en      = 1'b1;
            state_next = S_FILL;
          end else begin
            finish     = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_FILL: begin
        nos_next   = rd_data;
        finish     = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      depth     <= '0;
      count     <= '0;
      halted    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      depth  <= depth_next;
      count  <= count_next;
      halted <= halted_next;
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // stack top registers and result word
  always_ff @(posedge clk) begin
    tos <= tos_next;
    nos <= nos_next;
    if (finish) begin
      o_status <= st;
      o_top    <= (depth_next != '0) ? tos_next : 32'd0;
      o_empty  <= (depth_next == '0);
      o_count  <= count_next;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.status         = o_status;
  assign out_ch.top_value      = o_top;
  assign out_ch.stack_empty    = o_empty;
  assign out_ch.executed_count = o_count;

  assign mon.halted = halted;
  assign mon.busy   = (state != S_IDLE);

endmodule

FILE: src/stack_machine_execute_unit.sv
// channel  | dir | fields
// in_ch    | in  | op[3:0], immediate[31:0] signed
// out_ch   | out | status[2:0], top_value[31:0] signed, stack_empty, executed_count[31:0]
//
// Words enter a two-entry queue after decode; the back end executes one at a time.
// Most instructions complete from the idle state; pop, add, sub and mul pass through
// a refill state when a third entry is read back from the stack RAM's registered port.
// Div waits in a divide state for the radix-2 divider, then refills when one is needed.
// Synchronous reset empties the stack and queue and clears count and halt.
// A stalled output holds its word; the queue keeps accepting until full.
module stack_machine_execute_unit
  import smu_pkg::*;
#(
  parameter int STACK_DEPTH = 2048
) (
  input  logic      clk,
  input  logic      rst,
  smu_in_if.sink    in_ch,
  smu_out_if.source out_ch
);

  logic    q_valid;
  entry_t  q_entry;
  logic    q_pop;
  bk_mon_t mon;

  smu_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .q_pop   (q_pop)
  );

  smu_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .q_pop   (q_pop),
    .out_ch  (out_ch),
    .mon     (mon)
  );

`ifndef SYNTHESIS
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    mon.halted |=> mon.halted)
    else $error("halt flag cleared without reset");

  a_fault_halts: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.status != ST_OK |-> mon.halted)
    else $error("non-ok result without halt");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.stack_empty |-> out_ch.top_value == 32'sd0)
    else $error("empty stack with nonzero top");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    mon.busy |-> !q_pop)
    else $error("queue popped while back end busy");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import smu_pkg::*;

  localparam int STACK_DEPTH = 256;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_WORDS = 1800;
  localparam int HALTED_WORDS = 40;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_AFTER = 300;
  localparam int HOLD_CYCLES = 400;
  localparam logic [3:0] OP_UNKNOWN_LO = 4'd11;
  localparam logic [3:0] OP_UNKNOWN_HI = 4'd15;
  localparam logic [31:0] MAX_POS = 32'h7fffffff;
  localparam logic [31:0] MAX_NEG = 32'h80000000;

  // ending fault chosen once per run
  typedef enum int {
    END_OVERFLOW,
    END_UNDERFLOW,
    END_DIVZERO,
    END_UNKNOWN,
    END_QUIT
  } end_fault_t;

  typedef struct {
    status_t     status;
    logic [31:0] top;
    logic        empty;
    logic [31:0] count;
  } result_t;

  typedef struct {
    logic [3:0]  op;
    logic [31:0] imm;
    bit          typed;
    status_t     status;
    logic [31:0] top;
    logic        empty;
  } dir_row_t;

  // directed rows; count is the row number plus one
  localparam int DIR_ROWS = 19;
  const dir_row_t dir_rows [DIR_ROWS] = '{
    '{OP_NOP,  32'd0,        1, ST_OK, 32'd0,        1'b1},
    '{OP_PUSH, MAX_POS,      1, ST_OK, MAX_POS,      1'b0},
    '{OP_INC,  32'd0,        1, ST_OK, MAX_NEG,      1'b0},
    '{OP_DEC,  32'hffffffff, 1, ST_OK, MAX_POS,      1'b0},
    '{OP_PUSH, MAX_NEG,      1, ST_OK, MAX_NEG,      1'b0},
    '{OP_PUSH, 32'hffffffff, 1, ST_OK, 32'hffffffff, 1'b0},
    '{OP_DIV,  32'd0,        1, ST_OK, MAX_NEG,      1'b0},
    '{OP_SWAP, 32'd0,        1, ST_OK, MAX_POS,      1'b0},
    '{OP_SUB,  32'd0,        1, ST_OK, 32'd1,        1'b0},
    '{OP_PUSH, 32'd7,        1, ST_OK, 32'd7,        1'b0},
    '{OP_MUL,  32'd0,        1, ST_OK, 32'd7,        1'b0},
    '{OP_PUSH, 32'hfffffffe, 1, ST_OK, 32'hfffffffe, 1'b0},
    '{OP_DIV,  32'd0,        1, ST_OK, 32'hfffffffd, 1'b0},
    '{OP_PUSH, 32'hdeadbeef, 0, ST_OK, 32'd0,        1'b0},
    '{OP_PUSH, 32'h0001ffff, 0, ST_OK, 32'd0,        1'b0},
    '{OP_MUL,  32'd0,        0, ST_OK, 32'd0,        1'b0},
    '{OP_ADD,  32'd0,        0, ST_OK, 32'd0,        1'b0},
    '{OP_NOP,  32'd0,        0, ST_OK, 32'd0,        1'b0},
    '{OP_POP,  32'd0,        1, ST_OK, 32'd0,        1'b1}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  smu_in_if in_ch();
  smu_out_if out_ch();

  stack_machine_execute_unit #(.STACK_DEPTH(STACK_DEPTH)) DUT (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  always #2 clk = ~clk;

  // machine state mirrored by the predictor
  logic [31:0] stack_mem [STACK_DEPTH];
  int          depth;
  logic [31:0] exec_count;
  bit          is_halted;

  result_t pending_results [$];
  int      mismatches;
  int      cycles;
  int      results_seen;
  bit      stim_done;

  // advance the mirrored machine by one instruction and return its result
  function automatic result_t execute_word(logic [3:0] op, logic [31:0] imm);
    result_t     r;
    status_t     st;
    logic [31:0] a, b, ma, mb, q;
    st = ST_OK;
    if (is_halted) begin
      st = ST_HALTED;
    end else begin
      if (exec_count != 32'hffffffff) exec_count++;
      case (op)
        OP_NOP: ;
        OP_PUSH: begin
          if (depth >= STACK_DEPTH) st = ST_OVERFLOW;
          else begin
            stack_mem[depth] = imm;
            depth++;
          end
        end
        OP_POP: begin
          if (depth == 0) st = ST_UNDERFLOW;
          else depth--;
        end
        OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
          if (depth < 2) st = ST_UNDERFLOW;
          else if (op == OP_DIV && stack_mem[depth-1] == 0) st = ST_DIVZERO;
          else begin
            a = stack_mem[depth-2];
            b = stack_mem[depth-1];
            case (op)
              OP_ADD: q = a + b;
              OP_SUB: q = a - b;
              OP_MUL: q = a * b;
              default: begin
                // divide magnitudes, then fix the sign; wraps on min / -1
                ma = a[31] ? -a : a;
                mb = b[31] ? -b : b;
                q = ma / mb;
                if (a[31] != b[31]) q = -q;
              end
            endcase
            stack_mem[depth-2] = q;
            depth--;
          end
        end
        OP_SWAP: begin
          if (depth < 2) st = ST_UNDERFLOW;
          else begin
            a = stack_mem[depth-1];
            stack_mem[depth-1] = stack_mem[depth-2];
            stack_mem[depth-2] = a;
          end
        end
        OP_INC, OP_DEC: begin
          if (depth == 0) st = ST_UNDERFLOW;
          else if (op == OP_INC) stack_mem[depth-1] = stack_mem[depth-1] + 1;
          else stack_mem[depth-1] = stack_mem[depth-1] - 1;
        end
        OP_QUIT: st = ST_QUIT;
        default: st = ST_UNKNOWN;
      endcase
      if (st != ST_OK) is_halted = 1;
    end
    r.status = st;
    r.top = (depth != 0) ? stack_mem[depth-1] : 32'd0;
    r.empty = (depth == 0);
    r.count = exec_count;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // stall counts come in stretches: busy ones draw 0..7, quiet ones none
  bit send_quiet;
  int send_count;

  // offer one word, then predict it once it is taken
  task automatic send_word(logic [3:0] op, logic [31:0] imm, bit typed, result_t want);
    int      gap;
    result_t r;
    if (send_count % 150 == 0) send_quiet = ($urandom_range(0, 2) == 0);
    send_count++;
    gap = send_quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.op = op;
    in_ch.immediate = imm;
    do @(posedge clk); while (!in_ch.ready);
    r = execute_word(op, imm);
    pending_results.push_back(typed ? want : r);
    @(negedge clk);
  endtask

  function automatic logic [31:0] random_value();
    case ($urandom_range(0, 5))
      0: return MAX_POS;
      1: return MAX_NEG;
      2: return 32'hffffffff;
      3: return 32'($urandom_range(0, 9)) - 32'd4;
      default: return $urandom;
    endcase
  endfunction

  // pick an instruction that keeps the machine running
  function automatic logic [3:0] legal_op();
    logic [3:0] op;
    int         pct;
    pct = $urandom_range(0, 99);
    if (pct < 32) op = OP_PUSH;
    else if (pct < 44) op = OP_POP;
    else if (pct < 52) op = OP_NOP;
    else op = 4'($urandom_range(OP_ADD, OP_DEC));
    if (op == OP_PUSH && depth >= STACK_DEPTH) op = OP_POP;
    if ((op == OP_POP || op == OP_INC || op == OP_DEC) && depth == 0) op = OP_PUSH;
    if (op >= OP_ADD && op <= OP_SWAP && depth < 2) op = OP_PUSH;
    if (op == OP_DIV && stack_mem[depth-1] == 0) op = OP_SWAP;
    return op;
  endfunction

  // stimulus
  initial begin
    result_t    want;
    logic [3:0] op;
    end_fault_t fault;
    in_ch.valid = 1'b0;
    in_ch.op = OP_NOP;
    in_ch.immediate = '0;
    depth = 0;
    exec_count = '0;
    is_halted = 0;
    mismatches = 0;
    stim_done = 0;
    send_count = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed rows
    for (int i = 0; i < DIR_ROWS; i++) begin
      want.status = dir_rows[i].status;
      want.top = dir_rows[i].top;
      want.empty = dir_rows[i].empty;
      want.count = 32'(i + 1);
      send_word(dir_rows[i].op, dir_rows[i].imm, dir_rows[i].typed, want);
    end

    // random well-formed program
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      op = legal_op();
      send_word(op, random_value(), 0, want);
    end

    // drive the machine into one fault or a quit
    fault = end_fault_t'($urandom_range(END_OVERFLOW, END_QUIT));
    case (fault)
      END_OVERFLOW: begin
        while (depth < STACK_DEPTH) send_word(OP_PUSH, $urandom, 0, want);
        send_word(OP_PUSH, $urandom, 0, want);
      end
      END_UNDERFLOW: begin
        while (depth > 0) send_word(OP_POP, $urandom, 0, want);
        send_word(4'($urandom_range(OP_POP, OP_DEC)), $urandom, 0, want);
      end
      END_DIVZERO: begin
        if (depth == 0) send_word(OP_PUSH, $urandom, 0, want);
        send_word(OP_PUSH, 32'd0, 0, want);
        send_word(OP_DIV, $urandom, 0, want);
      end
      END_UNKNOWN:
        send_word(4'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI)), $urandom, 0, want);
      default: send_word(OP_QUIT, $urandom, 0, want);
    endcase

    // everything after the halt is ignored
    for (int i = 0; i < HALTED_WORDS; i++) send_word(4'($urandom), $urandom, 0, want);
    in_ch.valid = 1'b0;
    stim_done = 1;
  end

  // result side: random stalls, one long hold, check each word
  initial begin
    int      stall;
    bit      held;
    bit      recv_quiet;
    result_t want;
    out_ch.ready = 1'b0;
    results_seen = 0;
    held = 0;
    recv_quiet = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (results_seen % 120 == 0) recv_quiet = ($urandom_range(0, 2) == 0);
      stall = recv_quiet ? 0 : $urandom_range(0, 7);
      if (!held && results_seen == HOLD_AFTER) begin
        held = 1;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      results_seen++;
      if (pending_results.size() == 0) begin
        report("unexpected word, status", 32'(out_ch.status), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status)
          report("status", 32'(out_ch.status), 32'(want.status));
        if (out_ch.top_value !== want.top) report("top_value", out_ch.top_value, want.top);
        if (out_ch.stack_empty !== want.empty)
          report("stack_empty", 32'(out_ch.stack_empty), 32'(want.empty));
        if (out_ch.executed_count !== want.count)
          report("executed_count", out_ch.executed_count, want.count);
      end
      @(negedge clk);
    end
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("stack_machine_execute_unit regression: fail");
        $finish;
      end
    end
  end

  // finish once every expected word has arrived and the block has settled
  initial begin
    wait (stim_done);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("stack_machine_execute_unit regression: pass");
    end else begin
      $display("stack_machine_execute_unit regression: fail");
    end
    $finish;
  end

endmodule
